/* hdl/dmtq_pkg.sv */
// Shared types and constants for the delayed message timer queue.
// No dependencies; the files that use it refer to it by scoped names.
package dmtq_pkg;

	localparam int TIME_W  = 48;
	localparam int NODE_W  = 16;
	localparam int MSG_W   = 32;
	localparam int DELAY_W = 32;
	localparam int SEQ_W   = 16;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// one stored entry of the slot table
	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [SEQ_W-1:0]  stamp;
		logic [NODE_W-1:0] node;
		logic [MSG_W-1:0]  message;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

	// sequencer to scan unit
	typedef struct packed {
		logic clear;       // start of a new item: drop previous results
		logic eval;        // entry data at the RAM output is to be examined
		logic slot_valid;  // valid bit of the entry being examined
	} scan_ctl_t;

	// scan unit to sequencer
	typedef struct packed {
		logic              found;
		logic              free_found;
		logic [SEQ_W-1:0]  best_age;
		logic [NODE_W-1:0] best_node;
		logic [MSG_W-1:0]  best_msg;
	} scan_res_t;

endpackage

/* hdl/dmtq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/dmtq_scan.sv */
// Shared compare unit: examines one slot per cycle, tracks the newest expired
// entry and the lowest free slot. Depends on dmtq_pkg.
module dmtq_scan #(
	parameter int SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dmtq_pkg::scan_ctl_t         ctl,
	input  logic [$clog2(SLOTS)-1:0]    idx,
	input  dmtq_pkg::slot_entry_t       entry,
	input  logic [dmtq_pkg::TIME_W-1:0] now,
	input  logic [dmtq_pkg::SEQ_W-1:0]  seq,
	output dmtq_pkg::scan_res_t         res,
	output logic [$clog2(SLOTS)-1:0]    best_idx,
	output logic [$clog2(SLOTS)-1:0]    free_idx
);

	localparam int IDX_W = $clog2(SLOTS);

	logic                       found_q;
	logic                       free_found_q;
	logic [IDX_W-1:0]           best_idx_q;
	logic [IDX_W-1:0]           free_idx_q;
	logic [dmtq_pkg::SEQ_W-1:0]  best_age_q;
	logic [dmtq_pkg::NODE_W-1:0] best_node_q;
	logic [dmtq_pkg::MSG_W-1:0]  best_msg_q;

	logic                       expired;
	logic [dmtq_pkg::SEQ_W-1:0] age;
	logic                       take;
	logic                       take_free;

	always_comb begin
		expired   = ctl.slot_valid && (entry.deadline <= now);
		age       = seq - entry.stamp;
		take      = ctl.eval && expired && (!found_q || (age < best_age_q));
		take_free = ctl.eval && !ctl.slot_valid && !free_found_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (take) begin
				found_q <= 1'b1;
			end
			if (take_free) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= idx;
			best_age_q  <= age;
			best_node_q <= entry.node;
			best_msg_q  <= entry.message;
		end
		if (take_free) begin
			free_idx_q <= idx;
		end
	end

	assign res.found      = found_q;
	assign res.free_found = free_found_q;
	assign res.best_age   = best_age_q;
	assign res.best_node  = best_node_q;
	assign res.best_msg   = best_msg_q;
	assign best_idx       = best_idx_q;
	assign free_idx       = free_idx_q;

endmodule

/* hdl/delayed_message_timer_queue.sv */
// Top level of the delayed message timer queue: sequencer, slot table RAM,
// valid bits and output register. Depends on dmtq_pkg, dmtq_ram, dmtq_scan.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  input   | in_valid / in_ready   | func, target_node, message_handle, delay
//  output  | out_valid / out_ready | delivered, out_node, out_message,
//          |                       | insert_dropped
//
// One item passes through the accept cycle, a scan in which the shared
// compare unit reads one table entry per cycle from the RAM port, a step for
// the last registered read, and a step to resolve and commit.
// A result waiting in the output register does not block the next transfer
// in; only the commit cycle holds until the output register is free.
// Reset clears the valid bits, fill count, time and sequence counters; the
// table RAM needs no clearing pass, since an entry is only used while valid.
module delayed_message_timer_queue #(
	parameter int SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [dmtq_pkg::NODE_W-1:0]   target_node,
	input  logic [dmtq_pkg::MSG_W-1:0]    message_handle,
	input  logic [dmtq_pkg::DELAY_W-1:0]  delay,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          delivered,
	output logic [dmtq_pkg::NODE_W-1:0]   out_node,
	output logic [dmtq_pkg::MSG_W-1:0]    out_message,
	output logic                          insert_dropped
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int TW    = dmtq_pkg::TIME_W;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;  // issue one RAM read per cycle
	localparam logic [1:0] S_LAST = 2'd2;  // examine the last read
	localparam logic [1:0] S_FIN  = 2'd3;  // resolve, commit, load result

	logic [1:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_s1;
	logic             eval_s1;
	logic [SLOTS-1:0] slot_valid_q;
	logic [CNT_W-1:0] count_q;
	logic [TW-1:0]    now_q;
	logic [dmtq_pkg::SEQ_W-1:0] seq_q;

	// accepted item
	logic                        ins_ok_q;
	logic                        dropped_q;
	logic [TW-1:0]               deadline_q;
	logic [dmtq_pkg::SEQ_W-1:0]  stamp_q;
	logic [dmtq_pkg::NODE_W-1:0] node_q;
	logic [dmtq_pkg::MSG_W-1:0]  msg_q;

	// output register
	logic                        out_valid_q;
	logic                        delivered_q;
	logic [dmtq_pkg::NODE_W-1:0] out_node_q;
	logic [dmtq_pkg::MSG_W-1:0]  out_msg_q;
	logic                        dropped_out_q;

	logic                  accept;
	logic                  is_insert;
	logic                  table_full;
	logic [TW:0]           dl_sum;
	logic [TW-1:0]         dl_sat;
	logic                  fin_go;
	logic                  new_exp;
	logic                  new_wins;
	logic                  deliver;

	dmtq_pkg::slot_entry_t wentry;
	dmtq_pkg::slot_entry_t rentry;
	dmtq_pkg::scan_ctl_t   sctl;
	dmtq_pkg::scan_res_t   sres;
	logic [IDX_W-1:0]      best_idx;
	logic [IDX_W-1:0]      free_idx;

	always_comb begin
		in_ready   = (state_q == S_IDLE);
		accept     = in_valid && in_ready;
		is_insert  = (func == dmtq_pkg::FUNC_INSERT);
		table_full = (count_q == CNT_W'(SLOTS));
		// deadline = now + delay, saturate at the top of the time range
		dl_sum     = {1'b0, now_q} + {{(TW + 1 - dmtq_pkg::DELAY_W){1'b0}}, delay};
		dl_sat     = dl_sum[TW] ? dmtq_pkg::TIME_MAX : dl_sum[TW-1:0];

		fin_go  = (state_q == S_FIN) && (!out_valid_q || out_ready);
		new_exp = (deadline_q <= now_q);
		// new entry has age one; an older entry wins on a smaller age, or
		// on an equal age from a lower slot
		new_wins = ins_ok_q && new_exp &&
			(!sres.found || (sres.best_age > dmtq_pkg::SEQ_W'(1)) ||
			 ((sres.best_age == dmtq_pkg::SEQ_W'(1)) && (free_idx < best_idx)));
		deliver  = sres.found || new_wins;

		sctl.clear      = accept;
		sctl.eval       = eval_s1;
		sctl.slot_valid = slot_valid_q[idx_s1];

		wentry.deadline = deadline_q;
		wentry.stamp    = stamp_q;
		wentry.node     = node_q;
		wentry.message  = msg_q;
	end

	dmtq_ram #(
		.WIDTH(dmtq_pkg::ENTRY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (fin_go && ins_ok_q),
		.waddr(free_idx),
		.wdata(wentry),
		.raddr(idx_q),
		.rdata(rentry)
	);

	dmtq_scan #(
		.SLOTS(SLOTS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (sctl),
		.idx     (idx_s1),
		.entry   (rentry),
		.now     (now_q),
		.seq     (seq_q),
		.res     (sres),
		.best_idx(best_idx),
		.free_idx(free_idx)
	);

	// sequencer, time, sequence count, fill count and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			idx_s1       <= '0;
			eval_s1      <= 1'b0;
			slot_valid_q <= '0;
			count_q      <= '0;
			now_q        <= '0;
			seq_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			eval_s1 <= (state_q == S_SCAN);
			idx_s1  <= idx_q;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= S_SCAN;
						// advance time on a tick, hold at the maximum
						if (!is_insert && (now_q != dmtq_pkg::TIME_MAX)) begin
							now_q <= now_q + TW'(1);
						end
						// stamp the insert with the old count, ages use the new one
						if (is_insert && !table_full) begin
							seq_q <= seq_q + dmtq_pkg::SEQ_W'(1);
						end
					end
				end
				S_SCAN: begin
					if (idx_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_LAST;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_LAST: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						count_q <= count_q + CNT_W'(ins_ok_q) - CNT_W'(deliver);
						if (ins_ok_q && !new_wins) begin
							slot_valid_q[free_idx] <= 1'b1;
						end
						if (sres.found && !new_wins) begin
							slot_valid_q[best_idx] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_ok_q   <= is_insert && !table_full;
			dropped_q  <= is_insert && table_full;
			deadline_q <= dl_sat;
			stamp_q    <= seq_q;
			node_q     <= target_node;
			msg_q      <= message_handle;
		end
	end

	// load the result; zero the payload when nothing is delivered
	always_ff @(posedge clk) begin
		if (fin_go) begin
			delivered_q   <= deliver;
			dropped_out_q <= dropped_q;
			if (new_wins) begin
				out_node_q <= node_q;
				out_msg_q  <= msg_q;
			end else if (sres.found) begin
				out_node_q <= sres.best_node;
				out_msg_q  <= sres.best_msg;
			end else begin
				out_node_q <= '0;
				out_msg_q  <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign delivered      = delivered_q;
	assign out_node       = out_node_q;
	assign out_message    = out_msg_q;
	assign insert_dropped = dropped_out_q;

endmodule

/* hdl/dmtq_checker.sv */
// Port-level checks for the delayed message timer queue, bound to the top.
// Depends on dmtq_pkg and delayed_message_timer_queue.
module dmtq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          delivered,
	input logic [dmtq_pkg::NODE_W-1:0]   out_node,
	input logic [dmtq_pkg::MSG_W-1:0]    out_message,
	input logic                          insert_dropped
);

	// a result held back keeps its transfer pending
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(delivered) && $stable(out_node) &&
			$stable(out_message) && $stable(insert_dropped))
		else $error("output payload changed while stalled");

	// the shared unit takes one item at a time
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transfer in");

	// an empty result carries no node or message
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !delivered |-> (out_node == '0) && (out_message == '0))
		else $error("payload set without a delivery");

endmodule

bind delayed_message_timer_queue dmtq_checker u_dmtq_checker (.*);
